// File: sv/lsbse_pkg.sv
// lsbse_pkg: types, codes and constants shared by the lsb stego payload extractor
// no dependencies

package lsbse_pkg;

  localparam int unsigned CHAR_BITS     = 8;
  localparam int unsigned SIZE_BITS_DEF = 32;
  localparam int unsigned HDR_W         = 10;
  localparam int unsigned MAGIC_W       = 16;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned KIND_W        = 2;

  localparam logic [HDR_W-1:0]   HEADER_BYTES_RST = HDR_W'(54);
  localparam logic [MAGIC_W-1:0] MAGIC_VALUE_RST  = 16'h2A23;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_BYTES = 1'b0,
    REG_MAGIC_VALUE  = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_MAGIC    = 3'd1,
    PH_EXT_LEN  = 3'd2,
    PH_EXT      = 3'd3,
    PH_DATA_LEN = 3'd4,
    PH_DATA     = 3'd5,
    PH_DONE     = 3'd6
  } phase_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_EXT  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] value;
    logic              last;
  } result_t;

endpackage

// File: sv/lsbse_parser.sv
// lsbse_parser: frame parser state and per-request next-state logic
// depends on lsbse_pkg

module lsbse_parser #(
  parameter int unsigned SIZE_BITS = lsbse_pkg::SIZE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic                         bit_i,
  input  logic                         start_of_image_i,
  input  logic [lsbse_pkg::HDR_W-1:0]  header_bytes_i,
  input  logic [lsbse_pkg::MAGIC_W-1:0] magic_value_i,
  output logic                         res_valid_o,
  output lsbse_pkg::result_t           res_o
);
  import lsbse_pkg::*;

  localparam int unsigned IDX_W = $clog2(SIZE_BITS);

  phase_e                 phase_q, phase_d;
  logic [HDR_W-1:0]       skip_q, skip_d;
  logic [SIZE_BITS-1:0]   acc_q, acc_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [BYTE_W-1:0]      mlow_q, mlow_d;
  logic [SIZE_BITS-1:0]   rem_q, rem_d;
  logic                   msec_q, msec_d;

  phase_e                 ph;
  logic [HDR_W-1:0]       skip;
  logic [SIZE_BITS-1:0]   acc, acc_n, rem, rem_dec;
  logic [IDX_W-1:0]       idx;
  logic [BYTE_W-1:0]      mlow, word;
  logic                   msec, char_full, size_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      skip_q  <= '0;
      acc_q   <= '0;
      idx_q   <= '0;
      mlow_q  <= '0;
      rem_q   <= '0;
      msec_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      acc_q   <= acc_d;
      idx_q   <= idx_d;
      mlow_q  <= mlow_d;
      rem_q   <= rem_d;
      msec_q  <= msec_d;
    end
  end

  always_comb begin
    // a new image restarts the parser on this very byte
    ph   = start_of_image_i ? PH_HEADER : phase_q;
    skip = start_of_image_i ? '0 : skip_q;
    acc  = start_of_image_i ? '0 : acc_q;
    idx  = start_of_image_i ? '0 : idx_q;
    mlow = start_of_image_i ? '0 : mlow_q;
    rem  = start_of_image_i ? '0 : rem_q;
    msec = start_of_image_i ? 1'b0 : msec_q;

    acc_n     = acc | (SIZE_BITS'(bit_i) << idx);
    word      = acc_n[BYTE_W-1:0];
    char_full = (idx == IDX_W'(CHAR_BITS - 1));
    size_full = (idx == IDX_W'(SIZE_BITS - 1));
    rem_dec   = rem - SIZE_BITS'(1);

    phase_d = ph;
    skip_d  = skip;
    acc_d   = acc;
    idx_d   = idx;
    mlow_d  = mlow;
    rem_d   = rem;
    msec_d  = msec;

    res_valid_o = 1'b0;
    res_o.kind  = KIND_EXT;
    res_o.value = '0;
    res_o.last  = 1'b0;

    if (ph == PH_HEADER) begin
      if (skip < header_bytes_i) begin
        skip_d = skip + HDR_W'(1);
      end else begin
        ph = PH_MAGIC;
        phase_d = PH_MAGIC;
      end
    end

    case (ph)
      PH_MAGIC: begin
        acc_d = acc_n;
        idx_d = idx + IDX_W'(1);
        if (char_full) begin
          idx_d = '0;
          acc_d = '0;
          if (!msec) begin
            mlow_d = word;
            msec_d = 1'b1;
          end else begin
            msec_d = 1'b0;
            if ({word, mlow} != magic_value_i) begin
              phase_d     = PH_DONE;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_ERR;
              res_o.last  = 1'b1;
            end else begin
              phase_d = PH_EXT_LEN;
            end
          end
        end
      end
      PH_EXT_LEN, PH_DATA_LEN: begin
        acc_d = acc_n;
        idx_d = idx + IDX_W'(1);
        if (size_full) begin
          idx_d = '0;
          acc_d = '0;
          rem_d = acc_n;
          if (ph == PH_EXT_LEN) begin
            phase_d = (acc_n == '0) ? PH_DATA_LEN : PH_EXT;
          end else begin
            phase_d = (acc_n == '0) ? PH_DONE : PH_DATA;
          end
        end
      end
      PH_EXT, PH_DATA: begin
        acc_d = acc_n;
        idx_d = idx + IDX_W'(1);
        if (char_full) begin
          idx_d       = '0;
          acc_d       = '0;
          rem_d       = rem_dec;
          res_valid_o = 1'b1;
          res_o.kind  = (ph == PH_EXT) ? KIND_EXT : KIND_DATA;
          res_o.value = word;
          res_o.last  = (rem_dec == '0);
          if (rem_dec == '0) begin
            phase_d = (ph == PH_EXT) ? PH_DATA_LEN : PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/lsb_stego_payload_extractor.sv
// lsb_stego_payload_extractor: top level, config registers and result register
// depends on lsbse_pkg and lsbse_parser

// Takes one image byte per cycle and recovers the frame hidden in bit 0 of the
// bytes after a configurable header: two magic characters, extension length,
// extension characters, payload length, payload bytes. Each extension character
// and payload byte comes out as one result (kind 0 or 1, last marks the end of
// a run); a magic mismatch gives one error result (kind 2) and the parser then
// ignores bytes until start_of_image_i. A request is taken while in_ready_o is
// high and its result appears in the output register on the next cycle;
// in_ready_o drops only while a held result is not taken, so the sustained rate
// is one byte per cycle, set by the single parser state update per request.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i.

module lsb_stego_payload_extractor #(
  parameter int unsigned SIZE_BITS = lsbse_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lsbse_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lsbse_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lsbse_pkg::BYTE_W-1:0]      image_byte_i,
  input  logic                              start_of_image_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lsbse_pkg::KIND_W-1:0]      kind_o,
  output logic [lsbse_pkg::BYTE_W-1:0]      value_o,
  output logic                              last_o
);
  import lsbse_pkg::*;

  logic [HDR_W-1:0]   header_bytes_q;
  logic [MAGIC_W-1:0] magic_value_q;
  logic               step;
  logic               res_valid;
  result_t            res;
  logic               out_valid_q, out_valid_d;
  result_t            out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_bytes_q <= HEADER_BYTES_RST;
      magic_value_q  <= MAGIC_VALUE_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_HEADER_BYTES: header_bytes_q <= cfg_data_i[HDR_W-1:0];
        REG_MAGIC_VALUE:  magic_value_q  <= cfg_data_i[MAGIC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  lsbse_parser #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .bit_i           (image_byte_i[0]),
    .start_of_image_i(start_of_image_i),
    .header_bytes_i  (header_bytes_q),
    .magic_value_i   (magic_value_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_q.kind;
  assign value_o     = out_q.value;
  assign last_o      = out_q.last;

endmodule

// File: sv/lsbse_checker.sv
// lsbse_checker: port-level assertions for lsb_stego_payload_extractor
// depends on lsbse_pkg; bound to the top level below

module lsbse_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [lsbse_pkg::KIND_W-1:0]      kind_o,
  input logic [lsbse_pkg::BYTE_W-1:0]      value_o,
  input logic                              last_o
);
  import lsbse_pkg::*;

  // held result stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(value_o)
      && $stable(last_o))
    else $error("result changed while stalled");

  // a new result needs an accepted request in the cycle before
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result without request");

  // error results carry zero and close the frame
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ERR |-> value_o == '0 && last_o)
    else $error("malformed error result");

  // empty output register never blocks input
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind lsb_stego_payload_extractor lsbse_checker u_lsbse_checker (.*);
